FILE: rtl/pic_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// pic_pkg
// Shared types and constants of the point-in-cylinder test.
// ============================================================================
package pic_pkg;

    // Default coordinate width (signed fixed point, 8 fraction bits)
    localparam int COORD_BITS_DEF = 24;

    // Register file: 7 registers of at most 32 bits at byte address 4*i
    localparam int REG_IDX_W  = 3;
    localparam int APB_ADDR_W = REG_IDX_W + 2;

    localparam logic [REG_IDX_W-1:0] REG_FACE1_X    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FACE1_Y    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FACE1_Z    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FACE2_X    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FACE2_Y    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_FACE2_Z    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_CYL_RADIUS = 3'd6;

    // Stage enables of the split multiplier
    typedef struct packed {
        logic pp_en;    // load partial products
        logic sum_en;   // load assembled product
    } pic_mul_ctl_t;

endpackage

FILE: rtl/pic_if.sv
`timescale 1ns / 1ps
// ============================================================================
// pic_if
// Stream channels of the point-in-cylinder test: point in, flag out.
// ============================================================================
interface pic_pt_if
    import pic_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pt_x;
    logic signed [COORD_BITS-1:0] pt_y;
    logic signed [COORD_BITS-1:0] pt_z;

    modport source (output valid, output pt_x, output pt_y, output pt_z, input ready);
    modport sink   (input valid, input pt_x, input pt_y, input pt_z, output ready);
endinterface

interface pic_res_if;
    logic valid;
    logic ready;
    logic inside_res;

    modport source (output valid, output inside_res, input ready);
    modport sink   (input valid, input inside_res, output ready);
endinterface

FILE: rtl/pic_wide_mul.sv
`timescale 1ns / 1ps
// ============================================================================
// pic_wide_mul
// Two-stage unsigned multiplier: four half-width partial products, then sum.
// ============================================================================
module pic_wide_mul
    import pic_pkg::*;
#(
    parameter int W = 2 * COORD_BITS_DEF + 2
)
(
    input  logic             clk,
    input  pic_mul_ctl_t     ctl,
    input  logic [W-1:0]     a_in,
    input  logic [W-1:0]     b_in,
    output logic [2*W-1:0]   prod
);
    localparam int LO = W / 2;
    localparam int HI = W - LO;

    logic [HI-1:0]      a_hi, b_hi;
    logic [LO-1:0]      a_lo, b_lo;
    logic [2*HI-1:0]    hh_next, hh_reg;
    logic [HI+LO-1:0]   hl_next, hl_reg, lh_next, lh_reg;
    logic [2*LO-1:0]    ll_next, ll_reg;
    logic [2*W-1:0]     mid;
    logic [2*W-1:0]     prod_next, prod_reg;

    assign a_hi = a_in[W-1:LO];
    assign a_lo = a_in[LO-1:0];
    assign b_hi = b_in[W-1:LO];
    assign b_lo = b_in[LO-1:0];

    assign hh_next = (2*HI)'(a_hi) * (2*HI)'(b_hi);
    assign hl_next = (HI+LO)'(a_hi) * (HI+LO)'(b_lo);
    assign lh_next = (HI+LO)'(a_lo) * (HI+LO)'(b_hi);
    assign ll_next = (2*LO)'(a_lo) * (2*LO)'(b_lo);

    assign mid       = (2*W)'(hl_reg) + (2*W)'(lh_reg);
    assign prod_next = ((2*W)'(hh_reg) << (2*LO)) + (mid << LO) + (2*W)'(ll_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.pp_en)
        begin
            hh_reg <= hh_next;
            hl_reg <= hl_next;
            lh_reg <= lh_next;
            ll_reg <= ll_next;
        end
        if (ctl.sum_en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/point_in_cylinder_test.sv
`timescale 1ns / 1ps
// ============================================================================
// point_in_cylinder_test
// Says whether a 3D point lies inside a configured cylinder.
// ============================================================================
// One point enters per clock while the pipeline is not backed up; the rate is
// one word per cycle, set by the 8-stage pipeline in which every multiplier
// has its own stage. ready propagates back through per-stage valid bits, so a
// bubble anywhere lets a new point in even while the output word is stalled.
// With a = face2 - face1, d = pt - face1, t = a.d, L = |a|^2, D = |d|^2 the
// point is inside when t >= 0, t < L and D*L < t^2 + r^2*L, all compared
// exactly on integers (no root, no division). A zero-length axis gives 0, as
// do face2 and mantle points; points inside the face1 disc give 1. Registers
// (APB, 4*i addresses): face1 x/y/z, face2 x/y/z, radius; write them only
// while no point is in flight. Writes above the last register are dropped.
//
// Stages:
//   S1  a and d (one subtract per coordinate of each vector)
//   S2  nine (COORD_BITS+1)^2 signed products and r^2
//   S3  three-term sums: t, L, D
//   S4  range check on t, |t|
//   S5  half-width partial products of D*L, |t|^2, r^2*L
//   S6  partial products assembled
//   S7  t^2 + r^2*L
//   S8  final compare, output register
// ============================================================================
module point_in_cylinder_test
    import pic_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,

    pic_pt_if.sink                pt_ch,
    pic_res_if.source             res_ch
);
    localparam int N    = COORD_BITS;
    localparam int PW   = 2 * N + 2;    // products, L, D, |t|
    localparam int TW   = 2 * N + 3;    // signed t
    localparam int RW   = 2 * N - 2;    // r^2
    localparam int SW   = 4 * N + 5;    // t^2 + r^2*L
    localparam int NSTG = 8;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [N-1:0] face1_x_reg, face1_y_reg, face1_z_reg;
    logic signed [N-1:0] face2_x_reg, face2_y_reg, face2_z_reg;
    logic [N-2:0]        cyl_radius_reg;
    logic                cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face1_x_reg    <= '0;
            face1_y_reg    <= '0;
            face1_z_reg    <= '0;
            face2_x_reg    <= '0;
            face2_y_reg    <= '0;
            face2_z_reg    <= '0;
            cyl_radius_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_FACE1_X:    face1_x_reg    <= pwdata[N-1:0];
                REG_FACE1_Y:    face1_y_reg    <= pwdata[N-1:0];
                REG_FACE1_Z:    face1_z_reg    <= pwdata[N-1:0];
                REG_FACE2_X:    face2_x_reg    <= pwdata[N-1:0];
                REG_FACE2_Y:    face2_y_reg    <= pwdata[N-1:0];
                REG_FACE2_Z:    face2_z_reg    <= pwdata[N-1:0];
                REG_CYL_RADIUS: cyl_radius_reg <= pwdata[N-2:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_FACE1_X:    prdata = 32'(unsigned'(face1_x_reg));
            REG_FACE1_Y:    prdata = 32'(unsigned'(face1_y_reg));
            REG_FACE1_Z:    prdata = 32'(unsigned'(face1_z_reg));
            REG_FACE2_X:    prdata = 32'(unsigned'(face2_x_reg));
            REG_FACE2_Y:    prdata = 32'(unsigned'(face2_y_reg));
            REG_FACE2_Z:    prdata = 32'(unsigned'(face2_z_reg));
            REG_CYL_RADIUS: prdata = 32'(cyl_radius_reg);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when empty or when the next
    // one loads; the last one also when the output word is taken.
    // ------------------------------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] stg_en;

    always_comb
    begin
        stg_en[NSTG-1] = !vld_reg[NSTG-1] || res_ch.ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            stg_en[k] = !vld_reg[k] || stg_en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (stg_en[0])
            begin
                vld_reg[0] <= pt_ch.valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (stg_en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign pt_ch.ready  = stg_en[0];
    assign res_ch.valid = vld_reg[NSTG-1];

    // ------------------------------------------------------------------
    // S1: axis and offset vectors
    // ------------------------------------------------------------------
    logic signed [N:0] ax_next, ay_next, az_next, dx_next, dy_next, dz_next;
    logic signed [N:0] ax_reg, ay_reg, az_reg, dx_reg, dy_reg, dz_reg;
    logic [N-2:0]      rad1_reg;

    assign ax_next = (N+1)'(face2_x_reg) - (N+1)'(face1_x_reg);
    assign ay_next = (N+1)'(face2_y_reg) - (N+1)'(face1_y_reg);
    assign az_next = (N+1)'(face2_z_reg) - (N+1)'(face1_z_reg);
    assign dx_next = (N+1)'(pt_ch.pt_x) - (N+1)'(face1_x_reg);
    assign dy_next = (N+1)'(pt_ch.pt_y) - (N+1)'(face1_y_reg);
    assign dz_next = (N+1)'(pt_ch.pt_z) - (N+1)'(face1_z_reg);

    always_ff @(posedge clk)
    begin
        if (stg_en[0])
        begin
            ax_reg   <= ax_next;
            ay_reg   <= ay_next;
            az_reg   <= az_next;
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            dz_reg   <= dz_next;
            rad1_reg <= cyl_radius_reg;
        end
    end

    // ------------------------------------------------------------------
    // S2: coordinate products
    // ------------------------------------------------------------------
    logic signed [PW-1:0] adx_reg, ady_reg, adz_reg;
    logic signed [PW-1:0] aax_reg, aay_reg, aaz_reg;
    logic signed [PW-1:0] ddx_reg, ddy_reg, ddz_reg;
    logic [RW-1:0]        rr2_reg;

    always_ff @(posedge clk)
    begin
        if (stg_en[1])
        begin
            adx_reg <= PW'(ax_reg) * PW'(dx_reg);
            ady_reg <= PW'(ay_reg) * PW'(dy_reg);
            adz_reg <= PW'(az_reg) * PW'(dz_reg);
            aax_reg <= PW'(ax_reg) * PW'(ax_reg);
            aay_reg <= PW'(ay_reg) * PW'(ay_reg);
            aaz_reg <= PW'(az_reg) * PW'(az_reg);
            ddx_reg <= PW'(dx_reg) * PW'(dx_reg);
            ddy_reg <= PW'(dy_reg) * PW'(dy_reg);
            ddz_reg <= PW'(dz_reg) * PW'(dz_reg);
            rr2_reg <= RW'(rad1_reg) * RW'(rad1_reg);
        end
    end

    // ------------------------------------------------------------------
    // S3: dot products
    // ------------------------------------------------------------------
    logic signed [TW-1:0] t3_reg;
    logic [PW-1:0]        len3_reg, dsq3_reg;
    logic [RW-1:0]        rr3_reg;

    always_ff @(posedge clk)
    begin
        if (stg_en[2])
        begin
            t3_reg   <= TW'(adx_reg) + TW'(ady_reg) + TW'(adz_reg);
            len3_reg <= unsigned'(aax_reg) + unsigned'(aay_reg) + unsigned'(aaz_reg);
            dsq3_reg <= unsigned'(ddx_reg) + unsigned'(ddy_reg) + unsigned'(ddz_reg);
            rr3_reg  <= rr2_reg;
        end
    end

    // ------------------------------------------------------------------
    // S4: axial range check (0 <= t < L) and |t|
    // ------------------------------------------------------------------
    logic                 t_neg;
    logic                 t_below;
    logic [PW-1:0]        tabs_next;
    logic [PW-1:0]        tabs4_reg, len4_reg, dsq4_reg, rr4_reg;
    logic                 ok4_reg, ok5_reg, ok6_reg, ok7_reg;

    assign t_neg     = t3_reg[TW-1];
    assign t_below   = t3_reg < signed'({1'b0, len3_reg});
    assign tabs_next = t_neg ? PW'(-t3_reg) : PW'(t3_reg);

    always_ff @(posedge clk)
    begin
        if (stg_en[3])
        begin
            tabs4_reg <= tabs_next;
            len4_reg  <= len3_reg;
            dsq4_reg  <= dsq3_reg;
            rr4_reg   <= PW'(rr3_reg);
            ok4_reg   <= !t_neg && t_below;
        end
    end

    // ------------------------------------------------------------------
    // S5/S6: wide products
    // ------------------------------------------------------------------
    pic_mul_ctl_t       mul_ctl;
    logic [2*PW-1:0]    dl_prod, tt_prod, rl_prod;

    assign mul_ctl.pp_en  = stg_en[4];
    assign mul_ctl.sum_en = stg_en[5];

    pic_wide_mul #(.W(PW)) u_mul_dl
    (
        .clk  (clk),
        .ctl  (mul_ctl),
        .a_in (dsq4_reg),
        .b_in (len4_reg),
        .prod (dl_prod)
    );

    pic_wide_mul #(.W(PW)) u_mul_tt
    (
        .clk  (clk),
        .ctl  (mul_ctl),
        .a_in (tabs4_reg),
        .b_in (tabs4_reg),
        .prod (tt_prod)
    );

    pic_wide_mul #(.W(PW)) u_mul_rl
    (
        .clk  (clk),
        .ctl  (mul_ctl),
        .a_in (rr4_reg),
        .b_in (len4_reg),
        .prod (rl_prod)
    );

    always_ff @(posedge clk)
    begin
        if (stg_en[4])
        begin
            ok5_reg <= ok4_reg;
        end
        if (stg_en[5])
        begin
            ok6_reg <= ok5_reg;
        end
    end

    // ------------------------------------------------------------------
    // S7: right-hand side t^2 + r^2*L
    // ------------------------------------------------------------------
    logic [SW-1:0]   rhs7_reg;
    logic [2*PW-1:0] lhs7_reg;

    always_ff @(posedge clk)
    begin
        if (stg_en[6])
        begin
            rhs7_reg <= SW'(tt_prod) + SW'(rl_prod);
            lhs7_reg <= dl_prod;
            ok7_reg  <= ok6_reg;
        end
    end

    // ------------------------------------------------------------------
    // S8: radial compare, output word
    // ------------------------------------------------------------------
    logic res_reg;

    always_ff @(posedge clk)
    begin
        if (stg_en[7])
        begin
            res_reg <= ok7_reg && (SW'(lhs7_reg) < rhs7_reg);
        end
    end

    assign res_ch.inside_res = res_reg;

endmodule
